>>> rtl/rsts_pkg.sv
// ----------------------------------------------------------------------------
// rsts_pkg: shared types, constants and basis tables
// Fixed-point formats, basis selects and the seven Q2.14 basis ROMs used by
// the RGB to spectrum converter.
// ----------------------------------------------------------------------------
package rsts_pkg;

    // Number of wavelength samples per item (fixed by the item format)
    localparam int N_WL = 8;

    // Wavelength span 380..720 nm in Q10.6
    localparam logic [15:0] LAMBDA_LO = 16'd24320;
    localparam logic [15:0] LAMBDA_HI = 16'd46080;
    // Span width 21760 = 85 * 2^8
    localparam logic [14:0] SPAN      = 15'd21760;
    localparam int          SPAN_ODD  = 85;
    // Reciprocal of 85 in Q0.16, one short; fixed up by a remainder check
    localparam int          RECIP_85  = 771;

    // Lane pipeline depth in cycles
    localparam int LANE_LAT = 10;

    // Input queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // Basis selects
    typedef enum logic [2:0] {
        BASIS_WHITE   = 3'd0,
        BASIS_CYAN    = 3'd1,
        BASIS_MAGENTA = 3'd2,
        BASIS_YELLOW  = 3'd3,
        BASIS_RED     = 3'd4,
        BASIS_GREEN   = 3'd5,
        BASIS_BLUE    = 3'd6
    } t_basis;

    // Weights and bases for one colour
    typedef struct packed {
        logic [15:0] w1;
        logic [15:0] w2;
        logic [15:0] w3;
        t_basis      b2;
        t_basis      b3;
    } t_wgt;

    // Classified item held in the queue
    typedef struct packed {
        t_wgt                  wgt;
        logic [N_WL-1:0][15:0] wl;
    } t_item;

    localparam logic signed [15:0] ROM_WHITE [0:31] = '{
        16'sd17398, 16'sd17392, 16'sd17391, 16'sd17404, 16'sd17403, 16'sd17408,
        16'sd17406, 16'sd17408, 16'sd17408, 16'sd17407, 16'sd17401, 16'sd17389,
        16'sd17384, 16'sd17390, 16'sd17390, 16'sd17400, 16'sd17409, 16'sd17407,
        16'sd17408, 16'sd17407, 16'sd17408, 16'sd17409, 16'sd17409, 16'sd17406,
        16'sd17406, 16'sd17408, 16'sd17387, 16'sd17358, 16'sd17367, 16'sd17371,
        16'sd17369, 16'sd17378};

    localparam logic signed [15:0] ROM_CYAN [0:31] = '{
        16'sd17063, 16'sd16922, 16'sd16591, 16'sd16958, 16'sd16513, 16'sd17076,
        16'sd17109, 16'sd17261, 16'sd16680, 16'sd17109, 16'sd17251, 16'sd17264,
        16'sd17259, 16'sd17265, 16'sd17248, 16'sd17253, 16'sd17286, 16'sd17291,
        16'sd17128, 16'sd10215, 16'sd2955, -16'sd125, -16'sd2, -16'sd123,
        -16'sd36, 16'sd11, 16'sd201, -16'sd73, 16'sd280, 16'sd81,
        16'sd96, 16'sd414};

    localparam logic signed [15:0] ROM_MAGENTA [0:31] = '{
        16'sd16289, 16'sd16218, 16'sd16104, 16'sd16323, 16'sd16710, 16'sd16657,
        16'sd16746, 16'sd16327, 16'sd16544, 16'sd16737, 16'sd10491, 16'sd41,
        16'sd107, 16'sd46, 16'sd0, -16'sd148, 16'sd56, -16'sd50,
        16'sd3638, 16'sd10345, 16'sd15971, 16'sd15927, 16'sd16669, 16'sd16364,
        16'sd15516, 16'sd13969, 16'sd15548, 16'sd15524, 16'sd16318, 16'sd14140,
        16'sd14606, 16'sd13905};

    localparam logic signed [15:0] ROM_YELLOW [0:31] = '{
        16'sd91, -16'sd79, -16'sd86, -16'sd106, -16'sd98, -16'sd36,
        16'sd275, 16'sd1574, 16'sd3476, 16'sd5926, 16'sd8841, 16'sd12191,
        16'sd15108, 16'sd17138, 16'sd17226, 16'sd17223, 16'sd17220, 16'sd17232,
        16'sd17229, 16'sd17223, 16'sd17222, 16'sd17230, 16'sd17226, 16'sd17229,
        16'sd17222, 16'sd17228, 16'sd17218, 16'sd17218, 16'sd17166, 16'sd17192,
        16'sd17098, 16'sd17027};

    localparam logic signed [15:0] ROM_RED [0:31] = '{
        16'sd2716, 16'sd1941, 16'sd2033, 16'sd1863, 16'sd1294, 16'sd528,
        -16'sd177, 16'sd296, 16'sd88, 16'sd224, -16'sd98, -16'sd30,
        -16'sd173, -16'sd48, -16'sd177, -16'sd131, -16'sd37, 16'sd115,
        -16'sd134, 16'sd9957, 16'sd16193, 16'sd16284, 16'sd16448, 16'sd16259,
        16'sd16372, 16'sd16523, 16'sd16115, 16'sd16523, 16'sd15966, 16'sd16145,
        16'sd15318, 16'sd16173};

    localparam logic signed [15:0] ROM_GREEN [0:31] = '{
        16'sd43, -16'sd82, -16'sd206, -16'sd155, -16'sd205, -16'sd130,
        -16'sd131, -16'sd153, 16'sd1073, 16'sd6484, 16'sd12328, 16'sd15790,
        16'sd16360, 16'sd16383, 16'sd16374, 16'sd16383, 16'sd16374, 16'sd16369,
        16'sd15732, 16'sd10352, 16'sd4227, 16'sd154, -16'sd50, -16'sd74,
        -16'sd113, -16'sd148, -16'sd141, -16'sd137, -16'sd129, 16'sd0,
        16'sd89, -16'sd45};

    localparam logic signed [15:0] ROM_BLUE [0:31] = '{
        16'sd16255, 16'sd16200, 16'sd16308, 16'sd16307, 16'sd16250, 16'sd16388,
        16'sd16379, 16'sd16382, 16'sd16139, 16'sd12948, 16'sd9189, 16'sd5429,
        16'sd2243, 16'sd310, 16'sd0, -16'sd7, -16'sd7, 16'sd29,
        16'sd62, -16'sd9, -16'sd1, 16'sd124, 16'sd423, 16'sd625,
        16'sd811, 16'sd813, 16'sd816, 16'sd653, 16'sd500, 16'sd348,
        16'sd114, 16'sd68};

    // Basis entry lookup; bins past the table read as zero
    function automatic logic signed [15:0] basis_rom(t_basis which, logic [5:0] idx);
        logic signed [15:0] val;
        val = 16'sd0;
        if (!idx[5]) begin
            unique case (which)
                BASIS_WHITE:   val = ROM_WHITE[idx[4:0]];
                BASIS_CYAN:    val = ROM_CYAN[idx[4:0]];
                BASIS_MAGENTA: val = ROM_MAGENTA[idx[4:0]];
                BASIS_YELLOW:  val = ROM_YELLOW[idx[4:0]];
                BASIS_RED:     val = ROM_RED[idx[4:0]];
                BASIS_GREEN:   val = ROM_GREEN[idx[4:0]];
                BASIS_BLUE:    val = ROM_BLUE[idx[4:0]];
                default:       val = 16'sd0;
            endcase
        end
        return val;
    endfunction

endpackage

>>> rtl/rsts_in_if.sv
// ----------------------------------------------------------------------------
// rsts_in_if: input channel
// Valid/ready channel carrying one RGB colour and eight wavelengths.
// ----------------------------------------------------------------------------
interface rsts_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] wavelength_0;
    logic [15:0] wavelength_1;
    logic [15:0] wavelength_2;
    logic [15:0] wavelength_3;
    logic [15:0] wavelength_4;
    logic [15:0] wavelength_5;
    logic [15:0] wavelength_6;
    logic [15:0] wavelength_7;

    modport source (
        output valid, red, green, blue,
        output wavelength_0, wavelength_1, wavelength_2, wavelength_3,
        output wavelength_4, wavelength_5, wavelength_6, wavelength_7,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue,
        input  wavelength_0, wavelength_1, wavelength_2, wavelength_3,
        input  wavelength_4, wavelength_5, wavelength_6, wavelength_7,
        output ready
    );
endinterface

>>> rtl/rsts_out_if.sv
// ----------------------------------------------------------------------------
// rsts_out_if: output channel
// Valid/ready channel carrying eight spectral values.
// ----------------------------------------------------------------------------
interface rsts_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] spectral_0;
    logic [15:0] spectral_1;
    logic [15:0] spectral_2;
    logic [15:0] spectral_3;
    logic [15:0] spectral_4;
    logic [15:0] spectral_5;
    logic [15:0] spectral_6;
    logic [15:0] spectral_7;

    modport source (
        output valid, spectral_0, spectral_1, spectral_2, spectral_3,
        output spectral_4, spectral_5, spectral_6, spectral_7,
        input  ready
    );
    modport sink (
        input  valid, spectral_0, spectral_1, spectral_2, spectral_3,
        input  spectral_4, spectral_5, spectral_6, spectral_7,
        output ready
    );
endinterface

>>> rtl/rsts_front.sv
// ----------------------------------------------------------------------------
// rsts_front: item intake and classification
// Orders the three channels, derives the white / secondary / primary weights
// and bases, and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module rsts_front (
    rsts_in_if.sink          i_in,
    input  logic             i_full,
    output logic             o_push,
    output rsts_pkg::t_item  o_item
);

    logic [15:0] r, g, b;

    assign r = i_in.red;
    assign g = i_in.green;
    assign b = i_in.blue;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Channel ordering, ties resolved toward the earlier channel
    always_comb begin
        o_item.wgt = '0;
        // Wavelengths pass through untouched
        o_item.wl[0] = i_in.wavelength_0;
        o_item.wl[1] = i_in.wavelength_1;
        o_item.wl[2] = i_in.wavelength_2;
        o_item.wl[3] = i_in.wavelength_3;
        o_item.wl[4] = i_in.wavelength_4;
        o_item.wl[5] = i_in.wavelength_5;
        o_item.wl[6] = i_in.wavelength_6;
        o_item.wl[7] = i_in.wavelength_7;
        priority if (r <= g && r <= b) begin
            o_item.wgt.w1 = r;
            o_item.wgt.b2 = rsts_pkg::BASIS_CYAN;
            if (g <= b) begin
                o_item.wgt.w2 = g - r;
                o_item.wgt.w3 = b - g;
                o_item.wgt.b3 = rsts_pkg::BASIS_BLUE;
            end else begin
                o_item.wgt.w2 = b - r;
                o_item.wgt.w3 = g - b;
                o_item.wgt.b3 = rsts_pkg::BASIS_GREEN;
            end
        end else if (g <= r && g <= b) begin
            o_item.wgt.w1 = g;
            o_item.wgt.b2 = rsts_pkg::BASIS_MAGENTA;
            if (r <= b) begin
                o_item.wgt.w2 = r - g;
                o_item.wgt.w3 = b - r;
                o_item.wgt.b3 = rsts_pkg::BASIS_BLUE;
            end else begin
                o_item.wgt.w2 = b - g;
                o_item.wgt.w3 = r - b;
                o_item.wgt.b3 = rsts_pkg::BASIS_RED;
            end
        end else begin
            o_item.wgt.w1 = b;
            o_item.wgt.b2 = rsts_pkg::BASIS_YELLOW;
            if (r <= g) begin
                o_item.wgt.w2 = r - b;
                o_item.wgt.w3 = g - r;
                o_item.wgt.b3 = rsts_pkg::BASIS_GREEN;
            end else begin
                o_item.wgt.w2 = g - b;
                o_item.wgt.w3 = r - g;
                o_item.wgt.b3 = rsts_pkg::BASIS_RED;
            end
        end
    end

endmodule

>>> rtl/rsts_queue.sv
// ----------------------------------------------------------------------------
// rsts_queue: classified item queue
// Small FIFO between the front and the lane pipeline.
// ----------------------------------------------------------------------------
module rsts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rsts_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rsts_pkg::t_item  o_item
);

    rsts_pkg::t_item                 r_mem [rsts_pkg::Q_DEPTH];
    logic [rsts_pkg::Q_AW-1:0]       r_wr, n_wr;
    logic [rsts_pkg::Q_AW-1:0]       r_rd, n_rd;
    logic [rsts_pkg::Q_AW:0]         r_cnt, n_cnt;

    assign o_full  = (r_cnt == (rsts_pkg::Q_AW+1)'(rsts_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Pointer and fill count update
    always_comb begin
        n_wr  = r_wr + (rsts_pkg::Q_AW)'(i_push);
        n_rd  = r_rd + (rsts_pkg::Q_AW)'(i_pop);
        n_cnt = r_cnt + (rsts_pkg::Q_AW+1)'(i_push) - (rsts_pkg::Q_AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> rtl/rsts_lane.sv
// ----------------------------------------------------------------------------
// rsts_lane: one wavelength lane
// Ten-stage pipeline: bin position, bin index by reciprocal divide, basis
// lookup, interpolation, weighting, sum, rounding and saturation.
// ----------------------------------------------------------------------------
module rsts_lane #(
    parameter int BASIS_BINS = 32
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [15:0]     i_wl,
    input  rsts_pkg::t_wgt  i_wgt,
    output logic [15:0]     o_spectral
);

    localparam logic [5:0]  BINS_M1 = 6'(BASIS_BINS - 1);
    localparam logic [6:0]  BINS_M2 = 7'(BASIS_BINS - 2);
    localparam logic [51:0] HALF    = 52'(21760 * 8192);
    localparam logic [29:0] SAT_Y   = 30'(85 * 65536);

    rsts_pkg::t_wgt r_wgt [6];

    // Stage 1: clamp and scale to bin position
    logic [15:0] n_cl;
    logic [14:0] n_d;
    logic [20:0] r_p1;

    always_comb begin
        priority if (i_wl < rsts_pkg::LAMBDA_LO) n_cl = rsts_pkg::LAMBDA_LO;
        else if (i_wl > rsts_pkg::LAMBDA_HI)     n_cl = rsts_pkg::LAMBDA_HI;
        else                                     n_cl = i_wl;
        n_d = 15'(n_cl - rsts_pkg::LAMBDA_LO);
    end

    // Stage 2: coarse bin index from reciprocal of 85
    logic [22:0] n_iq;
    logic [20:0] r_p2;
    logic [5:0]  r_i0;

    assign n_iq = 23'(r_p1[20:8]) * 23'(rsts_pkg::RECIP_85);

    // Stage 3: index fix-up, remainder, top-of-span hold
    logic [12:0] n_rem3;
    logic [6:0]  n_i3;
    logic [14:0] n_r3;
    logic [5:0]  r_i3;
    logic [14:0] r_r3;

    always_comb begin
        n_rem3 = r_p2[20:8] - 13'(r_i0) * 13'(rsts_pkg::SPAN_ODD);
        n_i3   = 7'(r_i0);
        if (n_rem3 >= 13'(rsts_pkg::SPAN_ODD)) begin
            n_i3   = n_i3 + 7'd1;
            n_rem3 = n_rem3 - 13'(rsts_pkg::SPAN_ODD);
        end
        n_r3 = {n_rem3[6:0], r_p2[7:0]};
        if (n_i3 > BINS_M2) begin
            n_i3 = BINS_M2;
            n_r3 = rsts_pkg::SPAN;
        end
    end

    // Stage 4: basis lookups at both neighbors
    logic signed [15:0] r_lo [3];
    logic signed [15:0] r_hi [3];
    logic [14:0]        r_r4;
    logic [14:0]        r_rc4;
    logic [5:0]         n_i3p;

    assign n_i3p = r_i3 + 6'd1;

    // Stage 5: interpolation products
    logic signed [31:0] r_plo [3];
    logic signed [31:0] r_phi [3];

    // Stage 6: interpolated basis values, scaled by the span
    logic signed [32:0] r_v [3];

    // Stage 7: weighted terms
    logic signed [49:0] r_m [3];
    logic signed [16:0] n_w [3];

    assign n_w[0] = signed'({1'b0, r_wgt[5].w1});
    assign n_w[1] = signed'({1'b0, r_wgt[5].w2});
    assign n_w[2] = signed'({1'b0, r_wgt[5].w3});

    // Stage 8: sum, zero clamp, rounding offset, drop 2^22
    logic signed [51:0] n_s;
    logic [51:0]        n_x;
    logic [29:0]        r_y8;
    logic               r_zero8;

    always_comb begin
        n_s = 52'(r_m[0]) + 52'(r_m[1]) + 52'(r_m[2]);
        n_x = unsigned'(n_s) + HALF;
    end

    // Stage 9: saturation check and quotient estimate by 85
    logic [32:0] n_qq;
    logic [22:0] r_y9;
    logic [15:0] r_q0;
    logic        r_sat9;
    logic        r_zero9;

    assign n_qq = 33'(r_y8[22:0]) * 33'(rsts_pkg::RECIP_85);

    // Stage 10: quotient fix-up and output register
    logic [22:0] n_rem10;
    logic [15:0] n_out;
    logic [15:0] r_out;

    always_comb begin
        n_rem10 = r_y9 - 23'(r_q0) * 23'(rsts_pkg::SPAN_ODD);
        n_out   = (n_rem10 >= 23'(rsts_pkg::SPAN_ODD)) ? r_q0 + 16'd1 : r_q0;
        priority if (r_zero9) n_out = 16'd0;
        else if (r_sat9)      n_out = 16'hFFFF;
        else                  n_out = n_out;
    end

    // Pipeline registers, all advancing together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wgt[0] <= i_wgt;
            for (int k = 1; k < 6; k++) begin
                r_wgt[k] <= r_wgt[k-1];
            end

            r_p1 <= 21'(n_d) * 21'(BINS_M1);

            r_p2 <= r_p1;
            r_i0 <= n_iq[21:16];

            r_i3 <= n_i3[5:0];
            r_r3 <= n_r3;

            r_lo[0] <= rsts_pkg::basis_rom(rsts_pkg::BASIS_WHITE, r_i3);
            r_hi[0] <= rsts_pkg::basis_rom(rsts_pkg::BASIS_WHITE, n_i3p);
            r_lo[1] <= rsts_pkg::basis_rom(r_wgt[2].b2, r_i3);
            r_hi[1] <= rsts_pkg::basis_rom(r_wgt[2].b2, n_i3p);
            r_lo[2] <= rsts_pkg::basis_rom(r_wgt[2].b3, r_i3);
            r_hi[2] <= rsts_pkg::basis_rom(r_wgt[2].b3, n_i3p);
            r_r4    <= r_r3;
            r_rc4   <= rsts_pkg::SPAN - r_r3;

            for (int k = 0; k < 3; k++) begin
                r_plo[k] <= r_lo[k] * signed'({1'b0, r_rc4});
                r_phi[k] <= r_hi[k] * signed'({1'b0, r_r4});
                r_v[k]   <= 33'(r_plo[k]) + 33'(r_phi[k]);
                r_m[k]   <= 50'(n_w[k]) * 50'(r_v[k]);
            end

            r_y8    <= n_x[51:22];
            r_zero8 <= n_s[51] || (n_s == '0);

            r_y9    <= r_y8[22:0];
            r_q0    <= n_qq[31:16];
            r_sat9  <= (r_y8 >= SAT_Y);
            r_zero9 <= r_zero8;

            r_out <= n_out;
        end
    end

    assign o_spectral = r_out;

endmodule

>>> rtl/rgb_to_spectrum_smits.sv
// ----------------------------------------------------------------------------
// rgb_to_spectrum_smits: RGB to eight-sample spectrum converter
// Front classifies colours into a queue; lanes interpolate and weight three of the
// seven basis spectra at each wavelength.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one colour (Q4.12) and eight wavelengths (Q10.6 nm); o_out
//   returns eight spectral values (Q4.12), one result per input item.
//   Both channels are valid/ready; an item moves when both are high.
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// Path: an accepted item is written into the queue, and from the queue head
//   the 10-stage lane pipeline carries it to the output register.
// Stall: a held result freezes the lane pipeline; the 4-entry queue keeps
//   taking items until it fills, then i_in.ready drops.
// Reset: synchronous, active low; queue and valid pipeline are emptied.
// Lanes at or above LANES return zero.
// ----------------------------------------------------------------------------
module rgb_to_spectrum_smits #(
    parameter int BASIS_BINS = 32,
    parameter int LANES      = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsts_in_if.sink     i_in,
    rsts_out_if.source  o_out
);

    logic                    w_push;
    logic                    w_pop;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_en;
    rsts_pkg::t_item         w_in_item;
    rsts_pkg::t_item         w_head;
    logic [rsts_pkg::N_WL-1:0][15:0] w_spec;
    logic [rsts_pkg::LANE_LAT-1:0]   r_vld;

    // Front: accept and classify
    rsts_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_in_item)
    );

    // Queue between front and lanes
    rsts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    // Back pipeline advances unless a finished item is stalled
    assign w_en  = !r_vld[rsts_pkg::LANE_LAT-1] || o_out.ready;
    assign w_pop = w_en && !w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[rsts_pkg::LANE_LAT-2:0], w_pop};
        end
    end

    // Lanes
    for (genvar j = 0; j < rsts_pkg::N_WL; j++) begin : g_lane
        if (j < LANES) begin : g_on
            rsts_lane #(
                .BASIS_BINS (BASIS_BINS)
            ) u_lane (
                .i_clk      (i_clk),
                .i_en       (w_en),
                .i_wl       (w_head.wl[j]),
                .i_wgt      (w_head.wgt),
                .o_spectral (w_spec[j])
            );
        end else begin : g_off
            assign w_spec[j] = 16'd0;
        end
    end

    // Output channel
    assign o_out.valid      = r_vld[rsts_pkg::LANE_LAT-1];
    assign o_out.spectral_0 = w_spec[0];
    assign o_out.spectral_1 = w_spec[1];
    assign o_out.spectral_2 = w_spec[2];
    assign o_out.spectral_3 = w_spec[3];
    assign o_out.spectral_4 = w_spec[4];
    assign o_out.spectral_5 = w_spec[5];
    assign o_out.spectral_6 = w_spec[6];
    assign o_out.spectral_7 = w_spec[7];

`ifndef NO_ASSERTIONS
    // A stalled result keeps its lanes frozen
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(w_spec)))
        else $error("stalled result changed");

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    // An empty queue with no push stays empty and pops nothing
    a_queue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_empty && !w_push) |=> (w_empty && !w_pop))
        else $error("queue left empty state without a push");

    // A pop only happens while the back end advances
    a_pop_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_en && !w_empty))
        else $error("pop without advance");
`endif

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the RGB to spectrum converter
// Drives colours and wavelength sets through the valid/ready input, predicts
// each spectrum from the basis tables, and checks results in order, with
// random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [15:0] red, green, blue;
        logic [15:0] wl [8];
    } t_color_item;

    typedef struct {
        logic [15:0] val [8];
    } t_spectrum;

    function automatic longint basis_entry(rsts_pkg::t_basis which, int unsigned idx);
        case (which)
            rsts_pkg::BASIS_WHITE:   return rsts_pkg::ROM_WHITE[idx];
            rsts_pkg::BASIS_CYAN:    return rsts_pkg::ROM_CYAN[idx];
            rsts_pkg::BASIS_MAGENTA: return rsts_pkg::ROM_MAGENTA[idx];
            rsts_pkg::BASIS_YELLOW:  return rsts_pkg::ROM_YELLOW[idx];
            rsts_pkg::BASIS_RED:     return rsts_pkg::ROM_RED[idx];
            rsts_pkg::BASIS_GREEN:   return rsts_pkg::ROM_GREEN[idx];
            default:                 return rsts_pkg::ROM_BLUE[idx];
        endcase
    endfunction

    // Basis value at wavelength wl, scaled by the span width
    function automatic longint basis_at(rsts_pkg::t_basis which, logic [15:0] wl);
        int unsigned c, p, idx, rem;
        longint lo, hi;
        c = {16'd0, wl};
        if (c < 24320) c = 24320;
        if (c > 46080) c = 46080;
        p = (c - 24320) * 31;
        idx = p / 21760;
        rem = p - idx * 21760;
        if (idx > 30) begin
            idx = 30;
            rem = 21760;
        end
        lo = basis_entry(which, idx);
        hi = basis_entry(which, idx + 1);
        return lo * longint'(21760 - rem) + hi * longint'(rem);
    endfunction

    // Smits decomposition and weighted basis sum per lane
    function automatic t_spectrum predict_spectrum(t_color_item it);
        t_spectrum sp;
        longint r, g, b, w1, w2, w3, s, q;
        rsts_pkg::t_basis b2, b3;
        r = longint'(it.red); g = longint'(it.green); b = longint'(it.blue);
        if (r <= g && r <= b) begin
            w1 = r; b2 = rsts_pkg::BASIS_CYAN;
            if (g <= b) begin w2 = g - r; w3 = b - g; b3 = rsts_pkg::BASIS_BLUE; end
            else begin w2 = b - r; w3 = g - b; b3 = rsts_pkg::BASIS_GREEN; end
        end else if (g <= r && g <= b) begin
            w1 = g; b2 = rsts_pkg::BASIS_MAGENTA;
            if (r <= b) begin w2 = r - g; w3 = b - r; b3 = rsts_pkg::BASIS_BLUE; end
            else begin w2 = b - g; w3 = r - b; b3 = rsts_pkg::BASIS_RED; end
        end else begin
            w1 = b; b2 = rsts_pkg::BASIS_YELLOW;
            if (r <= g) begin w2 = r - b; w3 = g - r; b3 = rsts_pkg::BASIS_GREEN; end
            else begin w2 = g - b; w3 = r - g; b3 = rsts_pkg::BASIS_RED; end
        end
        for (int j = 0; j < 8; j++) begin
            s = w1 * basis_at(rsts_pkg::BASIS_WHITE, it.wl[j])
              + w2 * basis_at(b2, it.wl[j])
              + w3 * basis_at(b3, it.wl[j]);
            q = 0;
            if (s > 0) begin
                q = (s + 64'd21760 * 8192) / (64'd21760 * 16384);
                if (q > 65535) q = 65535;
            end
            sp.val[j] = q[15:0];
        end
        return sp;
    endfunction

    int errors = 0;

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // In-order store of predicted spectra
    class spectrum_board;
        t_spectrum pending[$];
        int checked = 0;

        function void note_input(t_color_item it);
            pending.push_back(predict_spectrum(it));
        endfunction

        task check_result(t_spectrum got);
            t_spectrum want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", int'(got.val[0]), 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            for (int j = 0; j < 8; j++)
                if (got.val[j] !== want.val[j])
                    report_mismatch($sformatf("spectral_%0d", j), int'(got.val[j]),
                                    int'(want.val[j]));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    rsts_in_if  in_ch();
    rsts_out_if out_ch();

    rgb_to_spectrum_smits DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    spectrum_board board = new();
    int  cycles = 0;
    bit  calm = 1'b0;      // no idling on either side
    int  hold_off = 0;     // long receiver stall
    t_color_item sent_item;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout");
            $display("simulation failed");
            $finish;
        end
    end

    // Accept monitor: note inputs and check results at the rising edge
    always @(posedge i_clk) begin
        t_spectrum got;
        if (i_rst_n && in_ch.valid && in_ch.ready) board.note_input(sent_item);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.val = '{out_ch.spectral_0, out_ch.spectral_1, out_ch.spectral_2,
                        out_ch.spectral_3, out_ch.spectral_4, out_ch.spectral_5,
                        out_ch.spectral_6, out_ch.spectral_7};
            board.check_result(got);
        end
    end

    // Receiver readiness, changed at the falling edge
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic send_item(t_color_item it);
        while (!calm && $urandom_range(99) < 12) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        sent_item = it;
        in_ch.valid <= 1'b1;
        in_ch.red <= it.red; in_ch.green <= it.green; in_ch.blue <= it.blue;
        in_ch.wavelength_0 <= it.wl[0]; in_ch.wavelength_1 <= it.wl[1];
        in_ch.wavelength_2 <= it.wl[2]; in_ch.wavelength_3 <= it.wl[3];
        in_ch.wavelength_4 <= it.wl[4]; in_ch.wavelength_5 <= it.wl[5];
        in_ch.wavelength_6 <= it.wl[6]; in_ch.wavelength_7 <= it.wl[7];
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic t_color_item make_item(logic [15:0] r, logic [15:0] g,
                                              logic [15:0] b, int mode);
        t_color_item it;
        it.red = r; it.green = g; it.blue = b;
        for (int j = 0; j < 8; j++) begin
            case (mode)
                0: it.wl[j] = 16'($urandom_range(46080, 24320));
                1: it.wl[j] = 16'($urandom());
                default: it.wl[j] = 16'(24320 + j * 3108);
            endcase
        end
        return it;
    endfunction

    // Random channel: full range or small (at most 8192 or 4096); ties are forced in the item loop
    function automatic logic [15:0] rand_chan();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1: return 16'($urandom_range(8192));
            default: return 16'($urandom_range(4096));
        endcase
    endfunction

    initial begin
        t_color_item it;
        logic [15:0] r, g, b;
        in_ch.valid = 1'b0;
        in_ch.red = '0; in_ch.green = '0; in_ch.blue = '0;
        in_ch.wavelength_0 = '0; in_ch.wavelength_1 = '0;
        in_ch.wavelength_2 = '0; in_ch.wavelength_3 = '0;
        in_ch.wavelength_4 = '0; in_ch.wavelength_5 = '0;
        in_ch.wavelength_6 = '0; in_ch.wavelength_7 = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: span edges, out-of-span, every ordering and ties
        it = make_item(16'd4096, 16'd4096, 16'd4096, 2);
        it.wl = '{16'd0, 16'd24319, 16'd24320, 16'd24321,
                  16'd46079, 16'd46080, 16'd46081, 16'hFFFF};
        send_item(it);
        it.red = 16'hFFFF; it.green = 16'hFFFF; it.blue = 16'hFFFF;
        send_item(it);
        it.red = 16'd0; it.green = 16'd0; it.blue = 16'd0;
        send_item(it);
        send_item(make_item(100, 200, 300, 2));
        send_item(make_item(100, 300, 200, 2));
        send_item(make_item(200, 100, 300, 2));
        send_item(make_item(300, 100, 200, 2));
        send_item(make_item(200, 300, 100, 2));
        send_item(make_item(300, 200, 100, 2));
        send_item(make_item(500, 500, 900, 2));
        send_item(make_item(500, 900, 500, 2));
        send_item(make_item(900, 500, 500, 2));
        send_item(make_item(900, 900, 500, 2));
        send_item(make_item(16'hFFFF, 0, 0, 2));
        send_item(make_item(0, 16'hFFFF, 0, 2));
        send_item(make_item(0, 0, 16'hFFFF, 2));
        send_item(make_item(16'hFFFF, 16'hFFFF, 0, 1));
        send_item(make_item(16'h5555, 16'hAAAA, 16'h0F0F, 1));

        // Random items, with a calm stretch and a long hold-off
        for (int n = 0; n < 1350; n++) begin
            calm = (n >= 400 && n < 600);
            if (n == 800) hold_off = 300;
            r = rand_chan(); g = rand_chan(); b = rand_chan();
            case ($urandom_range(5))
                0: g = r;
                1: b = g;
                2: b = r;
                default: ;
            endcase
            send_item(make_item(r, g, b, ($urandom_range(3) == 0) ? 1 : 0));
        end
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("covered %0d checked spectra: all channel orderings, ties,", board.checked);
        $display("out-of-span wavelengths, random stalls and one long hold-off");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
